// ===== rtl/core/wdt_regs_pkg.sv =====
// Package for the watchdog register block: register offsets, opcodes, key and bit positions.
// It depends on nothing. The module watchdog_timer_regs uses it.
`timescale 1ns / 1ps

package wdt_regs_pkg;

   localparam int CountWidth = 64;
   localparam int DataWidth  = 32;
   localparam int OffWidth   = 4;
   localparam int OpWidth    = 2;

   typedef logic [OpWidth-1:0]  opcode_type;
   typedef logic [OffWidth-1:0] offset_type;
   typedef logic [DataWidth-1:0] word_type;
   typedef logic [CountWidth-1:0] count_type;

   localparam opcode_type OP_TICK  = 2'd0;
   localparam opcode_type OP_WRITE = 2'd1;
   localparam opcode_type OP_READ  = 2'd2;

   localparam offset_type REG_PROTECT = 4'h0;
   localparam offset_type REG_ENABLE  = 4'h2;
   localparam offset_type REG_COMPARE = 4'h4;
   localparam offset_type REG_COUNTER = 4'h8;
   localparam offset_type REG_CONTROL = 4'hc;

   localparam logic [7:0] UNLOCK_KEY = 8'h96;
   localparam int RUN_BIT   = 4;
   localparam int CLEAR_BIT = 0;

endpackage

// ===== rtl/core/watchdog_timer_regs.sv =====
// Watchdog register block: 64-bit tick counter, write-protected compare/enable, sticky expiry.
// Depends on wdt_regs_pkg.
`timescale 1ns / 1ps

//  channel | ports                                   | dir | handshake
//  req     | req_opcode/offset/write_data/clock_gate_on | in  | req_valid / req_ready
//  rsp     | rsp_read_data/expired/counting          | out | rsp_valid / rsp_ready
//
// One item per cycle while the output is not stalled: the register update and the result
// are done in the accept cycle, the result lands in an output register. A second (skid)
// register takes one more item while the output is stalled; req_ready drops only when both
// are full. Synchronous reset clears the counter, compare, enable, lock and expiry flag,
// and empties both result registers.
module watchdog_timer_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  wdt_regs_pkg::opcode_type      req_opcode,
   input  wdt_regs_pkg::offset_type      req_offset,
   input  wdt_regs_pkg::word_type        req_write_data,
   input  logic                          req_clock_gate_on,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output wdt_regs_pkg::word_type        rsp_read_data,
   output logic                          rsp_expired,
   output logic                          rsp_counting
);
   import wdt_regs_pkg::*;

   typedef struct packed {
      word_type read_data;
      logic     expired;
      logic     counting;
   } result_type;

   count_type  count_ff, count_in;
   word_type   compare_ff, compare_in;
   word_type   enable_ff, enable_in;
   logic       unlocked_ff, unlocked_in;
   logic       timed_out_ff, timed_out_in;

   result_type out_ff, out_in, skid_ff, item_res;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;

   logic       accept, wr_op, running;
   word_type   rdata;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign wr_op     = (req_opcode == OP_WRITE);

   // Register state update for the accepted item
   always_comb begin
      enable_in   = enable_ff;
      compare_in  = compare_ff;
      unlocked_in = unlocked_ff;
      count_in    = count_ff;
      if (wr_op) begin
         case (req_offset)
            REG_PROTECT: unlocked_in = (req_write_data[7:0] == UNLOCK_KEY);
            REG_CONTROL: if (req_write_data[CLEAR_BIT]) count_in = '0;
            REG_COMPARE: if (unlocked_ff) compare_in = req_write_data;
            REG_ENABLE:  if (unlocked_ff) enable_in = req_write_data;
            default: ;
         endcase
      end
      // Enable never changes on a tick, so the stored run bit is the one to use
      running = enable_in[RUN_BIT] && req_clock_gate_on;
      if (req_opcode == OP_TICK && running)
         count_in = count_ff + count_type'(1);
      timed_out_in = timed_out_ff
         || ((compare_in != '0) && running && (count_in >= count_type'(compare_in)));
   end

   always_comb begin
      rdata = '0;
      if (req_opcode == OP_READ) begin
         case (req_offset)
            REG_PROTECT: rdata = unlocked_ff ? word_type'(UNLOCK_KEY) : '0;
            REG_ENABLE:  rdata = enable_ff;
            REG_COMPARE: rdata = compare_ff;
            REG_COUNTER: rdata = count_ff[DataWidth-1:0];
            default:     rdata = '0;
         endcase
      end
      item_res.read_data = rdata;
      item_res.expired   = timed_out_in;
      item_res.counting  = running;
   end

   // Output register plus skid stage
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end
      if (accept) begin
         if (!out_valid_in) begin
            out_in       = item_res;
            out_valid_in = 1'b1;
         end else begin
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         compare_ff    <= '0;
         enable_ff     <= '0;
         unlocked_ff   <= 1'b0;
         timed_out_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            compare_ff   <= compare_in;
            enable_ff    <= enable_in;
            unlocked_ff  <= unlocked_in;
            timed_out_ff <= timed_out_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (accept && out_valid_in && !(!out_valid_ff || (rsp_ready && !skid_valid_ff)))
         skid_ff <= item_res;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_ff.read_data;
   assign rsp_expired   = out_ff.expired;
   assign rsp_counting  = out_ff.counting;

endmodule

// ===== sim/watchdog_timer_regs_test.sv =====
// Self-checking testbench for watchdog_timer_regs: directed register accesses, then random
// program/tick/read sequences with random idling on both sides. Depends on wdt_regs_pkg.
`timescale 1ns / 1ps

module watchdog_timer_regs_test;
   import wdt_regs_pkg::*;

   typedef struct packed {
      word_type read_data;
      logic     expired;
      logic     counting;
   } wdt_result_type;

   // Tracks the watchdog state and keeps the results each accepted item should produce.
   class wdt_scoreboard;
      count_type      ticks = '0;
      word_type       compare_word = '0;
      word_type       enable_word = '0;
      bit             unlocked;
      bit             expired_flag;
      wdt_result_type pending_results[$];
      int             errors;

      function void note_item(opcode_type op, offset_type off, word_type data, logic gate);
         wdt_result_type res;
         res.read_data = '0;
         case (op)
            OP_TICK: begin
               if (enable_word[RUN_BIT] && gate)
                  ticks = ticks + 1;
            end
            OP_WRITE: begin
               case (off)
                  REG_PROTECT: unlocked = (data[7:0] == UNLOCK_KEY);
                  REG_CONTROL: if (data[CLEAR_BIT]) ticks = '0;
                  REG_COMPARE: if (unlocked) compare_word = data;
                  REG_ENABLE:  if (unlocked) enable_word = data;
                  default: ;
               endcase
            end
            OP_READ: begin
               case (off)
                  REG_PROTECT: res.read_data = unlocked ? word_type'(UNLOCK_KEY) : '0;
                  REG_ENABLE:  res.read_data = enable_word;
                  REG_COMPARE: res.read_data = compare_word;
                  REG_COUNTER: res.read_data = ticks[DataWidth-1:0];
                  default:     res.read_data = '0;
               endcase
            end
            default: ;
         endcase
         // running test uses the enable value after this item's write
         res.counting = enable_word[RUN_BIT] && gate;
         if (compare_word != '0 && res.counting && ticks >= count_type'(compare_word))
            expired_flag = 1'b1;
         res.expired = expired_flag;
         pending_results.push_back(res);
      endfunction

      function void check_result(word_type rdata, logic expired, logic counting);
         wdt_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing outstanding: read_data %h expired %b counting %b",
                     $time, rdata, expired, counting);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (rdata !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, want.read_data, rdata);
            errors++;
         end
         if (expired !== want.expired) begin
            $display("%0t: expired expected %b actual %b", $time, want.expired, expired);
            errors++;
         end
         if (counting !== want.counting) begin
            $display("%0t: counting expected %b actual %b", $time, want.counting, counting);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   localparam opcode_type OP_SPARE        = 2'd3;
   localparam offset_type REG_UNMAPPED_HI = 4'hf;
   localparam offset_type REG_UNMAPPED_LO = 4'h1;
   localparam int         ITEM_TARGET     = 850;
   localparam int         CYCLE_LIMIT     = 100000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   opcode_type req_opcode = OP_TICK;
   offset_type req_offset = REG_PROTECT;
   word_type   req_write_data = '0;
   logic       req_clock_gate_on = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   word_type   rsp_read_data;
   logic       rsp_expired;
   logic       rsp_counting;

   int            items_sent = 0;
   int            cycles = 0;
   wdt_scoreboard board = new();

   watchdog_timer_regs uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_offset(req_offset),
      .req_write_data(req_write_data),
      .req_clock_gate_on(req_clock_gate_on),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_expired(rsp_expired),
      .rsp_counting(rsp_counting)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("watchdog_timer_regs_test: done, errors");
         $finish;
      end
   end

   // check first: an item's result can never show up in its own accept cycle
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_read_data, rsp_expired, rsp_counting);
         if (req_valid && req_ready)
            board.note_item(req_opcode, req_offset, req_write_data, req_clock_gate_on);
      end
   end

   // receiver: one long hold-off to back up the block, one stretch with no stalls
   initial begin : rsp_side
      int cyc;
      cyc = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc >= 300 && cyc < 370)
            rsp_ready = 1'b0;
         else if (cyc >= 600 && cyc < 900)
            rsp_ready = 1'b1;
         else
            rsp_ready = ($urandom_range(99) >= 7);
      end
   end

   // called at a falling edge, returns at a falling edge after the item is taken
   task automatic send_item(input opcode_type op, input offset_type off,
                            input word_type data, input logic gate);
      if ((items_sent < 400 || items_sent >= 600) && $urandom_range(99) < 7) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_opcode        = op;
      req_offset        = off;
      req_write_data    = data;
      req_clock_gate_on = gate;
      req_valid         = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input offset_type off, input word_type data);
      send_item(OP_WRITE, off, data, 1'($urandom_range(1)));
   endtask

   task automatic read_reg(input offset_type off);
      send_item(OP_READ, off, $urandom, 1'($urandom_range(1)));
   endtask

   task automatic program_watchdog();
      word_type cmp;
      word_type en;
      word_type lock_word;
      int       pick;
      write_reg(REG_PROTECT, {24'($urandom_range(32'hffffff)), UNLOCK_KEY});
      pick = $urandom_range(99);
      if (pick < 55)      cmp = $urandom_range(64, 1);
      else if (pick < 85) cmp = $urandom;
      else                cmp = '0;
      write_reg(REG_COMPARE, cmp);
      en = $urandom;
      en[RUN_BIT] = ($urandom_range(99) < 80);
      write_reg(REG_ENABLE, en);
      if ($urandom_range(1)) read_reg(REG_COMPARE);
      if ($urandom_range(1)) read_reg(REG_ENABLE);
      lock_word = $urandom;
      if (lock_word[7:0] == UNLOCK_KEY) lock_word[0] = ~lock_word[0];
      if ($urandom_range(99) < 80) write_reg(REG_PROTECT, lock_word);
      if ($urandom_range(1)) write_reg(REG_CONTROL, $urandom | 32'h1);
   endtask

   task automatic tick_burst();
      int n;
      n = $urandom_range(20, 1);
      repeat (n) send_item(OP_TICK, offset_type'($urandom_range(15)), $urandom,
                           $urandom_range(99) < 85);
      if ($urandom_range(1)) read_reg(REG_COUNTER);
   endtask

   initial begin : req_side
      int pick;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // locked after reset, protected writes dropped
      read_reg(REG_PROTECT);
      write_reg(REG_ENABLE, 32'hffff_ffff);
      read_reg(REG_ENABLE);
      // key is only the low byte
      write_reg(REG_PROTECT, 32'hffff_ff96);
      read_reg(REG_PROTECT);
      // zero compare never expires
      write_reg(REG_COMPARE, 32'h0);
      write_reg(REG_ENABLE, 32'h0000_0010);
      repeat (3) send_item(OP_TICK, REG_PROTECT, 32'h0, 1'b1);
      send_item(OP_TICK, REG_UNMAPPED_HI, 32'hffff_ffff, 1'b0);
      read_reg(REG_COUNTER);
      write_reg(REG_COUNTER, 32'hffff_ffff);
      write_reg(REG_UNMAPPED_HI, 32'hffff_ffff);
      read_reg(REG_UNMAPPED_HI);
      read_reg(REG_UNMAPPED_LO);
      send_item(OP_SPARE, REG_COMPARE, 32'hffff_ffff, 1'b1);
      // control with clear bit low does nothing, high clears
      write_reg(REG_CONTROL, 32'hffff_fffe);
      read_reg(REG_COUNTER);
      write_reg(REG_CONTROL, 32'h0000_0001);
      read_reg(REG_COUNTER);
      // relock, compare write dropped
      write_reg(REG_PROTECT, 32'h0000_0000);
      write_reg(REG_COMPARE, 32'h0000_0005);
      read_reg(REG_COMPARE);
      write_reg(REG_PROTECT, 32'h0000_0096);
      write_reg(REG_COMPARE, 32'hffff_ffff);
      write_reg(REG_ENABLE, 32'hffff_ffef);
      read_reg(REG_ENABLE);

      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 20)
            program_watchdog();
         else if (pick < 55)
            tick_burst();
         else if (pick < 68)
            read_reg($urandom_range(1) ? REG_COUNTER : offset_type'($urandom_range(15)));
         else if (pick < 75)
            write_reg(REG_CONTROL, $urandom);
         else
            send_item(opcode_type'($urandom_range(3)), offset_type'($urandom_range(15)),
                      $urandom, 1'($urandom_range(1)));
      end

      req_valid = 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.errors == 0)
         $display("watchdog_timer_regs_test: done, clean");
      else
         $display("watchdog_timer_regs_test: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/wdt_regs_pkg.sv
rtl/core/watchdog_timer_regs.sv
sim/watchdog_timer_regs_test.sv
